// ===== rtl/btns_pkg.sv =====
// btns_pkg: shared constants, enum types and sizes for the b-tree node key store
// used by btns_ctrl, btns_dp and btree_node_sorted_key_store_unit; no dependencies
package btns_pkg;

  localparam int MAX_KEYS    = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int CHILD_DEPTH = MAX_KEYS + 1;

  // port field widths
  localparam int OP_W    = 2;
  localparam int IKEY_W  = 32;
  localparam int PAGE_W  = 31;
  localparam int ID_W    = 32;
  localparam int POS_W   = 5;
  localparam int STAT_W  = 2;

  // working index / count widths
  localparam int CNT_W   = $clog2(CHILD_DEPTH + 1);
  localparam int KIDX_W  = $clog2(MAX_KEYS);
  localparam int CIDX_W  = $clog2(CHILD_DEPTH);
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_INS_REC    = 2'd0,
    OP_SEARCH     = 2'd1,
    OP_INS_CHILD  = 2'd2,
    OP_FIND_CHILD = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_BEYOND    = 2'd3
  } status_e;

  // datapath micro-commands issued by the controller
  typedef enum logic [3:0] {
    DP_NOP,
    DP_START_KINS,
    DP_START_SRCH,
    DP_START_CINS,
    DP_START_CFIND,
    DP_KINS,
    DP_SFIRST,
    DP_SLAST,
    DP_BISECT,
    DP_CINS,
    DP_CFIND
  } dp_cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_KINS,
    S_SRCH_FIRST,
    S_SRCH_LAST,
    S_BISECT,
    S_CINS,
    S_CFIND,
    S_RESP
  } ctrl_state_e;

  // status returned by the datapath each cycle
  typedef struct packed {
    logic fin;
    logic key_full;
    logic child_full;
  } dp_stat_t;

  // sign-extend or truncate the key port to the stored key width
  function automatic logic signed [KEY_WIDTH-1:0] key_of(input logic [IKEY_W-1:0] raw);
    logic [KEY_WIDTH+IKEY_W-1:0] w;
    w = {{KEY_WIDTH{raw[IKEY_W-1]}}, raw};
    return w[KEY_WIDTH-1:0];
  endfunction

endpackage

// ===== rtl/btns_ctrl.sv =====
// btns_ctrl: operation sequencer for the b-tree node key store
// depends on btns_pkg; drives btns_dp by micro-commands, reads its status
module btns_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  logic [1:0]             operation_i,
  input  btns_pkg::dp_stat_t     stat_i,
  output btns_pkg::dp_cmd_e      cmd_o,
  output logic                   busy,
  output logic                   done_o
);
  import btns_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = DP_NOP;
    busy    = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      S_IDLE, S_RESP: begin
        busy   = 1'b0;
        done_o = (state_q == S_RESP);
        state_d = S_IDLE;
        if (start) begin
          case (op_e'(operation_i))
            OP_INS_REC: begin
              cmd_o   = DP_START_KINS;
              state_d = S_KINS;
            end
            OP_SEARCH: begin
              cmd_o   = DP_START_SRCH;
              state_d = S_SRCH_FIRST;
            end
            OP_INS_CHILD: begin
              cmd_o   = DP_START_CINS;
              state_d = S_CINS;
            end
            OP_FIND_CHILD: begin
              cmd_o   = DP_START_CFIND;
              state_d = S_CFIND;
            end
            default: begin
              cmd_o   = DP_NOP;
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_KINS: begin
        cmd_o = DP_KINS;
        if (stat_i.fin) state_d = S_RESP;
      end
      S_SRCH_FIRST: begin
        cmd_o   = DP_SFIRST;
        state_d = stat_i.fin ? S_RESP : S_SRCH_LAST;
      end
      S_SRCH_LAST: begin
        cmd_o   = DP_SLAST;
        state_d = stat_i.fin ? S_RESP : S_BISECT;
      end
      S_BISECT: begin
        cmd_o = DP_BISECT;
        if (stat_i.fin) state_d = S_RESP;
      end
      S_CINS: begin
        cmd_o = DP_CINS;
        if (stat_i.fin) state_d = S_RESP;
      end
      S_CFIND: begin
        cmd_o = DP_CFIND;
        if (stat_i.fin) state_d = S_RESP;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_busy_needs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start)) else $error("work began without a start");
  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without preceding work");
  a_full_insert_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_KINS && stat_i.key_full) |=> state_q == S_RESP)
    else $error("insert into full key list did not finish at once");
  a_full_child_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CINS && stat_i.child_full) |=> state_q == S_RESP)
    else $error("insert into full child list did not finish at once");

endmodule

// ===== rtl/btns_dp.sv =====
// btns_dp: key, page and child stores with their counts, index registers and result
// depends on btns_pkg; executes one micro-command from btns_ctrl per cycle
module btns_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  btns_pkg::dp_cmd_e              cmd_i,
  input  logic [btns_pkg::IKEY_W-1:0]    key_i,
  input  logic [btns_pkg::PAGE_W-1:0]    data_page_i,
  input  logic [btns_pkg::ID_W-1:0]      child_id_i,
  input  logic [btns_pkg::POS_W-1:0]     child_position_i,
  output btns_pkg::dp_stat_t             stat_o,
  output logic [btns_pkg::POS_W-1:0]     position_o,
  output logic [btns_pkg::STAT_W-1:0]    status_o
);
  import btns_pkg::*;

  logic signed [KEY_WIDTH-1:0] key_mem   [MAX_KEYS];
  logic        [PAGE_W-1:0]    page_mem  [MAX_KEYS];
  logic        [ID_W-1:0]      child_mem [CHILD_DEPTH];

  logic [CNT_W-1:0] key_cnt_q, key_cnt_d, child_cnt_q, child_cnt_d;
  logic [CNT_W-1:0] i_q, i_d, lo_q, lo_d, hi_q, hi_d;
  logic signed [KEY_WIDTH-1:0] k_q, k_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [POS_W-1:0]  cpos_q, cpos_d;
  logic [POS_W-1:0]  res_pos_q, res_pos_d;
  status_e           res_st_q, res_st_d;

  logic [CNT_W-1:0] piv, kaddr, caddr;
  logic signed [KEY_WIDTH-1:0] rd_key;
  logic [PAGE_W-1:0] rd_page;
  logic [ID_W-1:0]   rd_child;
  logic              fin;

  logic                        kwe, cwe;
  logic [CNT_W-1:0]            kwa, cwa;
  logic signed [KEY_WIDTH-1:0] kwd;
  logic [PAGE_W-1:0]           kwp;
  logic [ID_W-1:0]             cwd;

  assign piv = lo_q + ((hi_q - lo_q) >> 1);

  always_comb begin
    case (cmd_i)
      DP_KINS:   kaddr = i_q - CNT_W'(1);
      DP_SFIRST: kaddr = '0;
      DP_SLAST:  kaddr = key_cnt_q - CNT_W'(1);
      DP_BISECT: kaddr = (lo_q < hi_q) ? piv : lo_q;
      default:   kaddr = '0;
    endcase
  end

  assign caddr    = (cmd_i == DP_CFIND) ? i_q : i_q - CNT_W'(1);
  assign rd_key   = key_mem[kaddr[KIDX_W-1:0]];
  assign rd_page  = page_mem[kaddr[KIDX_W-1:0]];
  assign rd_child = child_mem[caddr[CIDX_W-1:0]];

  always_comb begin
    key_cnt_d   = key_cnt_q;
    child_cnt_d = child_cnt_q;
    i_d         = i_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    k_d         = k_q;
    page_d      = page_q;
    id_d        = id_q;
    cpos_d      = cpos_q;
    res_pos_d   = res_pos_q;
    res_st_d    = res_st_q;
    fin         = 1'b0;
    kwe         = 1'b0;
    kwa         = i_q;
    kwd         = k_q;
    kwp         = page_q;
    cwe         = 1'b0;
    cwa         = i_q;
    cwd         = id_q;

    if (cmd_i == DP_START_KINS || cmd_i == DP_START_SRCH ||
        cmd_i == DP_START_CINS || cmd_i == DP_START_CFIND) begin
      k_d    = key_of(key_i);
      page_d = data_page_i;
      id_d   = child_id_i;
      cpos_d = child_position_i;
    end

    case (cmd_i)
      DP_START_KINS:  i_d = key_cnt_q;
      DP_START_CINS:  i_d = child_cnt_q;
      DP_START_CFIND: i_d = '0;
      DP_KINS: begin
        if (key_cnt_q == CNT_W'(MAX_KEYS)) begin
          fin       = 1'b1;
          res_pos_d = '0;
          res_st_d  = STAT_FULL;
        end else if (i_q != '0 && rd_key > k_q) begin
          // move the larger entry up one place
          kwe = 1'b1;
          kwd = rd_key;
          kwp = rd_page;
          i_d = i_q - CNT_W'(1);
        end else begin
          kwe       = 1'b1;
          key_cnt_d = key_cnt_q + CNT_W'(1);
          fin       = 1'b1;
          res_pos_d = POS_W'(i_q);
          res_st_d  = STAT_OK;
        end
      end
      DP_SFIRST: begin
        lo_d = '0;
        hi_d = key_cnt_q - CNT_W'(1);
        if (key_cnt_q == '0 || rd_key > k_q) begin
          fin       = 1'b1;
          res_pos_d = '0;
          res_st_d  = STAT_NOT_FOUND;
        end
      end
      DP_SLAST: begin
        if (rd_key < k_q) begin
          fin       = 1'b1;
          res_pos_d = '0;
          res_st_d  = STAT_NOT_FOUND;
        end
      end
      DP_BISECT: begin
        if (lo_q < hi_q) begin
          if (k_q < rd_key) begin
            hi_d = piv;
          end else if (k_q == rd_key) begin
            fin       = 1'b1;
            res_pos_d = POS_W'(piv);
            res_st_d  = STAT_OK;
          end else begin
            lo_d = piv + CNT_W'(1);
          end
        end else begin
          fin = 1'b1;
          if (k_q == rd_key) begin
            res_pos_d = POS_W'(lo_q);
            res_st_d  = STAT_OK;
          end else begin
            res_pos_d = '0;
            res_st_d  = STAT_NOT_FOUND;
          end
        end
      end
      DP_CINS: begin
        if (child_cnt_q == CNT_W'(CHILD_DEPTH)) begin
          fin       = 1'b1;
          res_pos_d = '0;
          res_st_d  = STAT_FULL;
        end else if (CMP_W'(cpos_q) > CMP_W'(child_cnt_q)) begin
          fin       = 1'b1;
          res_pos_d = '0;
          res_st_d  = STAT_BEYOND;
        end else if (CMP_W'(i_q) > CMP_W'(cpos_q)) begin
          cwe = 1'b1;
          cwd = rd_child;
          i_d = i_q - CNT_W'(1);
        end else begin
          cwe         = 1'b1;
          child_cnt_d = child_cnt_q + CNT_W'(1);
          fin         = 1'b1;
          res_pos_d   = POS_W'(i_q);
          res_st_d    = STAT_OK;
        end
      end
      DP_CFIND: begin
        if (i_q < child_cnt_q) begin
          if (rd_child == id_q) begin
            fin       = 1'b1;
            res_pos_d = POS_W'(i_q);
            res_st_d  = STAT_OK;
          end else begin
            i_d = i_q + CNT_W'(1);
          end
        end else begin
          fin       = 1'b1;
          res_pos_d = '0;
          res_st_d  = STAT_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_cnt_q   <= '0;
      child_cnt_q <= '0;
    end else begin
      key_cnt_q   <= key_cnt_d;
      child_cnt_q <= child_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q       <= i_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    k_q       <= k_d;
    page_q    <= page_d;
    id_q      <= id_d;
    cpos_q    <= cpos_d;
    res_pos_q <= res_pos_d;
    res_st_q  <= res_st_d;
    if (kwe) begin
      key_mem[kwa[KIDX_W-1:0]]  <= kwd;
      page_mem[kwa[KIDX_W-1:0]] <= kwp;
    end
    if (cwe) begin
      child_mem[cwa[CIDX_W-1:0]] <= cwd;
    end
  end

  assign stat_o.fin        = fin;
  assign stat_o.key_full   = (key_cnt_q == CNT_W'(MAX_KEYS));
  assign stat_o.child_full = (child_cnt_q == CNT_W'(CHILD_DEPTH));
  assign position_o        = res_pos_q;
  assign status_o          = res_st_q;

  a_key_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_cnt_q <= CNT_W'(MAX_KEYS)) else $error("key count above capacity");
  a_child_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    child_cnt_q <= CNT_W'(CHILD_DEPTH)) else $error("child count above capacity");
  a_key_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_cnt_q != $past(key_cnt_q) |-> key_cnt_q == $past(key_cnt_q) + CNT_W'(1))
    else $error("key count moved by other than one");
  a_keys_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_cnt_q >= CNT_W'(2) |-> key_mem[0] <= key_mem[1])
    else $error("first two keys out of order");

endmodule

// ===== rtl/btree_node_sorted_key_store_unit.sv =====
// done_o is high in the cycle after the last work step
// each work step is one shift or compare per cycle through the single store read port
// throughput: a new start is taken in the cycle done_o is high; the receiver cannot stall
// reset: asynchronous, active low; clears both counts, store contents stay undefined
// until written and are only read below the counts
module btree_node_sorted_key_store_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command transaction
  input  logic                           start,
  output logic                           busy,
  input  logic [btns_pkg::OP_W-1:0]      operation_i,
  input  logic [btns_pkg::IKEY_W-1:0]    key_i,
  input  logic [btns_pkg::PAGE_W-1:0]    data_page_i,
  input  logic [btns_pkg::ID_W-1:0]      child_id_i,
  input  logic [btns_pkg::POS_W-1:0]     child_position_i,
  // result transaction, one cycle strobe
  output logic                           done_o,
  output logic [btns_pkg::POS_W-1:0]     position_o,
  output logic [btns_pkg::STAT_W-1:0]    status_o
);
  import btns_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_e  cmd;
  dp_stat_t stat;

  // sequencer: one state per phase of each operation, result state last
  btns_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (operation_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy        (busy),
    .done_o      (done_o)
  );

  // datapath: sorted key list shifts from the top down, so the scan for the
  // insert point and the shift share the same pass; search follows the
  // bisection order exactly so duplicates report the same index
  btns_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .key_i            (key_i),
    .data_page_i      (data_page_i),
    .child_id_i       (child_id_i),
    .child_position_i (child_position_i),
    .stat_o           (stat),
    .position_o       (position_o),
    .status_o         (status_o)
  );

endmodule
